// ===== hw/rtl/rtd_pkg.sv =====
package rtd_pkg;

    // Directory geometry. SET_COUNT and WAY_COUNT are powers of two of at least two.
    localparam int SET_COUNT   = 128;
    localparam int WAY_COUNT   = 16;
    localparam int TOKEN_WIDTH = 16;

    localparam int SET_BITS    = $clog2(SET_COUNT);
    localparam int WAY_BITS    = $clog2(WAY_COUNT);
    localparam int ENTRY_COUNT = SET_COUNT * WAY_COUNT;
    localparam int ENTRY_BITS  = SET_BITS + WAY_BITS;

    localparam int ADDR_W  = 48;
    localparam int TAG_W   = ADDR_W - SET_BITS;
    localparam int COUNT_W = 16;
    localparam int SLOT_W  = 4;
    localparam int CACHE_W = 8;

    // Token arithmetic width: wide enough for either operand plus a carry.
    localparam int SUM_W = ((TOKEN_WIDTH > COUNT_W) ? TOKEN_WIDTH : COUNT_W) + 1;

    localparam int SHORTCUT_MIN_SLOTS = 2;
    localparam int FORWARD_MIN_SLOTS  = 1;

    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_OFFSET = 2'd0,
        REG_FIRST_BELOW = 2'd1,
        REG_LAST_BELOW  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        MSG_REQUEST  = 3'd0,
        MSG_DATA_REQ = 3'd1,
        MSG_UPDATE   = 3'd2,
        MSG_DATA_TOK = 3'd3,
        MSG_EVICT    = 3'd4
    } msg_kind_t;

    typedef enum logic [1:0] {
        ROUTE_UP    = 2'd0,
        ROUTE_DOWN  = 2'd1,
        ROUTE_STALL = 2'd2
    } route_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_MISSING   = 2'd1,
        FAULT_UNDERFLOW = 2'd2,
        FAULT_SET_FULL  = 2'd3
    } fault_t;

    typedef struct packed {
        logic                   valid;
        logic [TAG_W-1:0]       tag;
        logic [TOKEN_WIDTH-1:0] tokens;
    } entry_t;

endpackage

// ===== hw/rtl/rtd_dir_ram.sv =====
module rtd_dir_ram (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [rtd_pkg::ENTRY_BITS-1:0] wr_addr,
    input  rtd_pkg::entry_t            wr_data,
    input  logic                       rd_en,
    input  logic [rtd_pkg::ENTRY_BITS-1:0] rd_addr,
    output rtd_pkg::entry_t            rd_data
);
    import rtd_pkg::*;

    entry_t mem [ENTRY_COUNT];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ring_token_directory.sv =====
// Token directory for one ring node. Each beat on s_ is one ring message and yields exactly
// one beat on m_ with its route, ignore mark, hit flag and fault code. A message that looks
// up its line goes through the way scan, which reads one way of the set per cycle through
// the single directory RAM read port and compares its tag in one shared comparator. After
// reset the block first clears the directory, one entry per cycle; s_tready stays low
// meanwhile, while configuration writes are taken at any time. A finished result is held
// in an output register, and the next message can be accepted while it waits.
module ring_token_directory (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input message. tuser: action [0], msg_kind [3:1].
    // tdata: byte_address [47:0], sender_cache [55:48], token_count [71:56],
    // ignore_in [72], upper_free_slots [76:73], lower_free_slots [80:77], zero fill above.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rtd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [rtd_pkg::IN_USER_W-1:0]  s_tuser,
    // Result. tdata: route [1:0], ignore_out [2], line_hit [3], fault [5:4], zero fill above.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rtd_pkg::OUT_DATA_W-1:0] m_tdata,
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rtd_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [3:0]         offset_reg;
    logic [CACHE_W-1:0] first_below_reg;
    logic [CACHE_W-1:0] last_below_reg;

    // Captured message.
    logic               action_reg;
    msg_kind_t          kind_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ign_reg;
    logic [SLOT_W-1:0]  up_free_reg;
    logic [SLOT_W-1:0]  low_free_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               lookup_reg;

    // Way scan.
    logic [ENTRY_BITS-1:0] clr_cnt_reg;
    logic [WAY_BITS:0]     way_cnt_reg;
    logic                  cmp_vld_reg;
    logic [WAY_BITS-1:0]   cmp_way_reg;
    logic                  hit_found_reg;
    logic [WAY_BITS-1:0]   hit_way_reg;
    logic [TOKEN_WIDTH-1:0] hit_tok_reg;
    logic                  free_found_reg;
    logic [WAY_BITS-1:0]   free_way_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Accept-side decode.
    logic               accept;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  in_line;
    logic               in_action;
    msg_kind_t          in_kind;
    logic [CACHE_W-1:0] in_sender;
    logic               in_below;
    logic               in_ign;
    logic [SLOT_W-1:0]  in_up_free;
    logic               in_lookup;

    // RAM interface.
    logic              ram_wr_en;
    logic [ENTRY_BITS-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    entry_t            ram_rd_data;

    // Decision.
    route_t            dec_route;
    logic              dec_ign;
    logic              dec_hit;
    fault_t            dec_fault;
    logic              dec_wr;
    entry_t            dec_entry;
    logic              dec_go;
    logic              alloc;
    logic              set_full;
    logic [SUM_W-1:0]  base_tok;
    logic [SUM_W-1:0]  count_ext;
    logic [SUM_W-1:0]  sum_tok;
    logic [SUM_W-1:0]  diff_tok;
    logic [SUM_W-1:0]  tok_max;
    logic [TOKEN_WIDTH-1:0] sat_tok;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign in_action  = s_tuser[0];
    assign in_kind    = msg_kind_t'(s_tuser[3:1]);
    assign in_addr    = s_tdata[47:0];
    assign in_sender  = s_tdata[55:48];
    assign in_ign     = s_tdata[72];
    assign in_up_free = s_tdata[76:73];
    assign in_line    = in_addr >> offset_reg;
    assign in_below   = (in_sender >= first_below_reg) && (in_sender <= last_below_reg);

    always_comb begin
        if (!in_action) begin
            in_lookup = (in_up_free >= SLOT_W'(FORWARD_MIN_SLOTS)) && !in_ign &&
                        ((in_kind == MSG_DATA_TOK) || (in_kind == MSG_EVICT));
        end else begin
            in_lookup = (in_kind == MSG_REQUEST) || (in_kind == MSG_DATA_REQ) ||
                        (in_kind == MSG_UPDATE) || ((in_kind == MSG_DATA_TOK) && in_below);
        end
    end

    // Token arithmetic on the hit or allocated entry.
    assign tok_max   = SUM_W'({TOKEN_WIDTH{1'b1}});
    assign count_ext = SUM_W'(count_reg);
    assign base_tok  = alloc ? '0 : SUM_W'(hit_tok_reg);
    assign sum_tok   = base_tok + count_ext;
    assign sat_tok   = (sum_tok > tok_max) ? {TOKEN_WIDTH{1'b1}} : sum_tok[TOKEN_WIDTH-1:0];
    assign diff_tok  = SUM_W'(hit_tok_reg) - count_ext;

    assign alloc    = lookup_reg && (kind_reg == MSG_DATA_TOK) && !hit_found_reg &&
                      free_found_reg;
    assign set_full = lookup_reg && (kind_reg == MSG_DATA_TOK) && !hit_found_reg &&
                      !free_found_reg;

    always_comb begin
        dec_route  = ROUTE_STALL;
        dec_ign    = 1'b0;
        dec_hit    = 1'b0;
        dec_fault  = FAULT_NONE;
        dec_wr     = 1'b0;
        dec_entry.valid  = 1'b1;
        dec_entry.tag    = tag_reg;
        dec_entry.tokens = sat_tok;
        if (!action_reg) begin
            if (up_free_reg >= SLOT_W'(FORWARD_MIN_SLOTS)) begin
                dec_route = ROUTE_UP;
                if (lookup_reg) begin
                    if (!hit_found_reg) begin
                        dec_fault = FAULT_MISSING;
                    end else begin
                        dec_hit = 1'b1;
                        if (SUM_W'(hit_tok_reg) < count_ext) begin
                            dec_fault = FAULT_UNDERFLOW;
                        end else begin
                            dec_wr           = 1'b1;
                            dec_entry.tokens = diff_tok[TOKEN_WIDTH-1:0];
                            dec_entry.valid  = (diff_tok != '0);
                        end
                    end
                end
            end
        end else if (hit_found_reg || alloc) begin
            if (low_free_reg >= SLOT_W'(FORWARD_MIN_SLOTS)) begin
                dec_route = ROUTE_DOWN;
                dec_ign   = ign_reg;
                dec_hit   = 1'b1;
                dec_wr    = (kind_reg == MSG_DATA_TOK);
            end
        end else begin
            dec_fault = set_full ? FAULT_SET_FULL : FAULT_NONE;
            if (up_free_reg >= SLOT_W'(SHORTCUT_MIN_SLOTS)) begin
                dec_route = ROUTE_UP;
                dec_ign   = ign_reg;
            end else if (low_free_reg >= SLOT_W'(FORWARD_MIN_SLOTS)) begin
                dec_route = ROUTE_DOWN;
                dec_ign   = 1'b1;
            end
        end
        // A stall leaves the directory and every flag untouched.
        if (dec_route == ROUTE_STALL) begin
            dec_ign   = 1'b0;
            dec_hit   = 1'b0;
            dec_fault = FAULT_NONE;
            dec_wr    = 1'b0;
        end
    end

    assign dec_go = (state_reg == S_DECIDE) && (!out_valid_reg || m_tready);

    always_comb begin
        ram_rd_en = (state_reg == S_SCAN) && (way_cnt_reg < (WAY_BITS+1)'(WAY_COUNT));
        if (state_reg == S_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = dec_go && dec_wr;
            ram_wr_addr = {set_reg, (hit_found_reg ? hit_way_reg : free_way_reg)};
            ram_wr_data = dec_entry;
        end
    end

    rtd_dir_ram u_dir_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr ({set_reg, way_cnt_reg[WAY_BITS-1:0]}),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            way_cnt_reg     <= '0;
            cmp_vld_reg     <= 1'b0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            offset_reg      <= 4'd6;
            first_below_reg <= '0;
            last_below_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_LINE_OFFSET: offset_reg      <= cfg_data[3:0];
                    REG_FIRST_BELOW: first_below_reg <= cfg_data;
                    REG_LAST_BELOW:  last_below_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // A new result may replace the one taken in this same cycle.
            if (dec_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            cmp_vld_reg <= ram_rd_en;
            cmp_way_reg <= way_cnt_reg[WAY_BITS-1:0];

            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ENTRY_BITS'(ENTRY_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        action_reg     <= in_action;
                        kind_reg       <= in_kind;
                        count_reg      <= s_tdata[71:56];
                        ign_reg        <= in_ign;
                        up_free_reg    <= in_up_free;
                        low_free_reg   <= s_tdata[80:77];
                        set_reg        <= in_line[SET_BITS-1:0];
                        tag_reg        <= in_line[ADDR_W-1:SET_BITS];
                        lookup_reg     <= in_lookup;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        way_cnt_reg    <= '0;
                        state_reg      <= in_lookup ? S_SCAN : S_DECIDE;
                    end
                end
                S_SCAN: begin
                    if (ram_rd_en) begin
                        way_cnt_reg <= way_cnt_reg + 1'b1;
                    end
                    // Read data arrives in the cycle after its address; keep the first match
                    // and the first free way.
                    if (cmp_vld_reg) begin
                        if (!hit_found_reg && ram_rd_data.valid &&
                            (ram_rd_data.tag == tag_reg)) begin
                            hit_found_reg <= 1'b1;
                            hit_way_reg   <= cmp_way_reg;
                            hit_tok_reg   <= ram_rd_data.tokens;
                        end
                        if (!free_found_reg && !ram_rd_data.valid) begin
                            free_found_reg <= 1'b1;
                            free_way_reg   <= cmp_way_reg;
                        end
                    end
                    if (!ram_rd_en && !cmp_vld_reg) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (dec_go) begin
                        out_data_reg  <= {2'b00, dec_fault, dec_hit, dec_ign, dec_route};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_stall_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_go && dec_route == ROUTE_STALL) |-> (!ram_wr_en && !dec_hit &&
        dec_fault == FAULT_NONE))
        else $error("stall must leave the directory and flags untouched");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        way_cnt_reg <= (WAY_BITS+1)'(WAY_COUNT))
        else $error("way scan ran past the last way");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("block took a message while still working on one");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("waiting result was overwritten");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

import rtd_pkg::*;

typedef struct {
    bit                 from_above;
    logic [2:0]         kind;
    logic [ADDR_W-1:0]  addr;
    logic [CACHE_W-1:0] sender;
    logic [COUNT_W-1:0] count;
    bit                 ign;
    logic [SLOT_W-1:0]  up_free;
    logic [SLOT_W-1:0]  low_free;
} ring_msg_t;

// Laid out so that the struct matches the low six bits of the result beat.
typedef struct packed {
    fault_t fault;
    logic   hit;
    logic   ign;
    route_t route;
} route_result_t;

class directory_scoreboard;
    logic                   dir_valid [ENTRY_COUNT];
    logic [TAG_W-1:0]       dir_tag [ENTRY_COUNT];
    logic [TOKEN_WIDTH-1:0] dir_tokens [ENTRY_COUNT];
    logic [3:0]             line_shift;
    logic [CACHE_W-1:0]     lo_id;
    logic [CACHE_W-1:0]     hi_id;
    route_result_t          route_q [$];
    int                     errors;

    function new();
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            dir_valid[i] = 1'b0;
            dir_tag[i] = '0;
            dir_tokens[i] = '0;
        end
        line_shift = 4'd6;
        lo_id = '0;
        hi_id = '0;
        errors = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_LINE_OFFSET: line_shift = value[3:0];
            REG_FIRST_BELOW: lo_id = value;
            REG_LAST_BELOW:  hi_id = value;
            default: ;
        endcase
    endfunction

    function int pending();
        return route_q.size();
    endfunction

    function int find_entry(int base, logic [TAG_W-1:0] tag);
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (dir_valid[base + w] && dir_tag[base + w] == tag) return base + w;
        end
        return -1;
    endfunction

    function void note_msg(ring_msg_t m);
        logic [ADDR_W-1:0] line;
        logic [TAG_W-1:0]  tag;
        logic [SUM_W-1:0]  sum;
        int                base;
        int                e;
        bit                alloc;
        route_result_t     r;

        line = m.addr >> line_shift;
        base = int'(line[SET_BITS-1:0]) * WAY_COUNT;
        tag = TAG_W'(line >> SET_BITS);
        r = '{fault: FAULT_NONE, hit: 1'b0, ign: 1'b0, route: ROUTE_STALL};
        e = -1;
        alloc = 1'b0;

        if (!m.from_above) begin
            if (m.up_free >= FORWARD_MIN_SLOTS) begin
                r.route = ROUTE_UP;
                if (!m.ign && (m.kind == MSG_DATA_TOK || m.kind == MSG_EVICT)) begin
                    e = find_entry(base, tag);
                    if (e < 0) begin
                        r.fault = FAULT_MISSING;
                    end else begin
                        r.hit = 1'b1;
                        if (dir_tokens[e] < m.count) begin
                            r.fault = FAULT_UNDERFLOW;
                        end else begin
                            dir_tokens[e] = TOKEN_WIDTH'(dir_tokens[e] - m.count);
                            if (dir_tokens[e] == 0) dir_valid[e] = 1'b0;
                        end
                    end
                end
            end
        end else begin
            if (m.kind <= MSG_UPDATE) begin
                e = find_entry(base, tag);
            end else if (m.kind == MSG_DATA_TOK && m.sender >= lo_id && m.sender <= hi_id) begin
                e = find_entry(base, tag);
                if (e < 0) begin
                    for (int w = 0; w < WAY_COUNT && e < 0; w++) begin
                        if (!dir_valid[base + w]) e = base + w;
                    end
                    if (e < 0) r.fault = FAULT_SET_FULL;
                    else alloc = 1'b1;
                end
            end
            if (e >= 0) begin
                // A held line only ever goes down; without room below the message waits.
                if (m.low_free >= FORWARD_MIN_SLOTS) begin
                    r.route = ROUTE_DOWN;
                    r.ign = m.ign;
                    r.hit = 1'b1;
                    if (m.kind == MSG_DATA_TOK) begin
                        sum = SUM_W'(m.count);
                        if (alloc) begin
                            dir_valid[e] = 1'b1;
                            dir_tag[e] = tag;
                        end else begin
                            sum = sum + SUM_W'(dir_tokens[e]);
                        end
                        if (sum > SUM_W'((64'd1 << TOKEN_WIDTH) - 1)) dir_tokens[e] = '1;
                        else dir_tokens[e] = TOKEN_WIDTH'(sum);
                    end
                end
            end else if (m.up_free >= SHORTCUT_MIN_SLOTS) begin
                r.route = ROUTE_UP;
                r.ign = m.ign;
            end else if (m.low_free >= FORWARD_MIN_SLOTS) begin
                r.route = ROUTE_DOWN;
                r.ign = 1'b1;
            end
        end

        if (r.route == ROUTE_STALL) begin
            r.ign = 1'b0;
            r.hit = 1'b0;
            r.fault = FAULT_NONE;
        end
        route_q.push_back(r);
    endfunction

    function void report(string field, int want, int got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] beat);
        route_result_t want;
        route_result_t got;

        if (route_q.size() == 0) begin
            $display("%0t: result beat %h arrived with no message outstanding", $time, beat);
            errors++;
            return;
        end
        want = route_q.pop_front();
        got = route_result_t'(beat[5:0]);
        if (got.route !== want.route) report("route", want.route, got.route);
        if (got.ign !== want.ign) report("ignore_out", want.ign, got.ign);
        if (got.hit !== want.hit) report("line_hit", want.hit, got.hit);
        if (got.fault !== want.fault) report("fault", want.fault, got.fault);
    endfunction
endclass

module tb;
    localparam bit         FROM_BELOW = 1'b0;
    localparam bit         FROM_ABOVE = 1'b1;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int         TAG_POOL = 22;
    localparam int         PHASE_ITEMS = 260;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    directory_scoreboard board = new();

    bit                 no_idle = 1'b0;
    logic [3:0]         cfg_shift = 4'd6;
    logic [CACHE_W-1:0] cfg_lo = '0;
    logic [CACHE_W-1:0] cfg_hi = '0;
    logic [TAG_W-1:0]   tag_pool [TAG_POOL];
    logic [SET_BITS-1:0] set_pool [2];

    ring_token_directory dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Byte address of a line built from the pools under the current line size.
    function automatic logic [ADDR_W-1:0] line_addr(int tag_idx, int set_idx);
        logic [ADDR_W+15:0] wide;
        logic [63:0]        low;
        wide = (ADDR_W + 16)'({tag_pool[tag_idx], set_pool[set_idx]}) << cfg_shift;
        low = {$urandom, $urandom} & ((64'd1 << cfg_shift) - 1);
        return ADDR_W'(wide | (ADDR_W + 16)'(low));
    endfunction

    function automatic logic [SLOT_W-1:0] free_slots();
        if ($urandom_range(0, 3) == 0) return SLOT_W'($urandom_range(0, 2));
        return SLOT_W'($urandom_range(0, 15));
    endfunction

    function automatic ring_msg_t mk(bit above, logic [2:0] kind, logic [ADDR_W-1:0] addr,
                                     logic [CACHE_W-1:0] sender, logic [COUNT_W-1:0] count,
                                     bit ign, logic [SLOT_W-1:0] up_free,
                                     logic [SLOT_W-1:0] low_free);
        ring_msg_t m;
        m.from_above = above;
        m.kind = kind;
        m.addr = addr;
        m.sender = sender;
        m.count = count;
        m.ign = ign;
        m.up_free = up_free;
        m.low_free = low_free;
        return m;
    endfunction

    function automatic ring_msg_t random_msg();
        ring_msg_t m;
        int        pick;
        m.from_above = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 30) m.kind = 3'($urandom_range(MSG_REQUEST, MSG_UPDATE));
        else if (pick < 65) m.kind = MSG_DATA_TOK;
        else if (pick < 90) m.kind = MSG_EVICT;
        else m.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        if ($urandom_range(0, 9) == 0) m.addr = ADDR_W'({$urandom, $urandom});
        else m.addr = line_addr($urandom_range(0, TAG_POOL - 1), $urandom_range(0, 1));
        if (m.from_above && m.kind == MSG_DATA_TOK && cfg_lo <= cfg_hi &&
            $urandom_range(0, 9) != 0)
            m.sender = CACHE_W'($urandom_range(cfg_lo, cfg_hi));
        else
            m.sender = CACHE_W'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 14) m.count = COUNT_W'($urandom_range(0, 3));
        else if (pick < 18) m.count = COUNT_W'($urandom);
        else m.count = '1;
        m.ign = ($urandom_range(0, 6) == 0);
        m.up_free = free_slots();
        m.low_free = free_slots();
        return m;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with s_tvalid low again.
    task automatic send_msg(ring_msg_t m);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {7'd0, m.low_free, m.up_free, m.ign, m.count, m.sender, m.addr};
        s_tuser = {m.kind, m.from_above};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_msg(m);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [3:0] shift, logic [CACHE_W-1:0] lo, logic [CACHE_W-1:0] hi);
        cfg_index_t            idx [3];
        logic [CFG_DATA_W-1:0] value [3];
        idx = '{REG_LINE_OFFSET, REG_FIRST_BELOW, REG_LAST_BELOW};
        value = '{{4'd0, shift}, lo, hi};
        for (int i = 0; i < 3; i++) begin
            cfg_valid = 1'b1;
            cfg_index = idx[i];
            cfg_data = value[i];
            do @(posedge aclk); while (!cfg_ready);
            board.write_reg(idx[i], value[i]);
            @(negedge aclk);
        end
        cfg_valid = 1'b0;
        cfg_shift = shift;
        cfg_lo = lo;
        cfg_hi = hi;
    endtask

    task automatic run_random(int items);
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 63) == 0) drain();
            if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
            send_msg(random_msg());
        end
    endtask

    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            board.check_result(m_tdata);
        end
    end

    initial begin
        logic [ADDR_W-1:0]  line_a;
        logic [ADDR_W-1:0]  line_b;
        logic [3:0]         shifts [4];
        logic [CACHE_W-1:0] los [4];
        logic [CACHE_W-1:0] his [4];

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_LINE_OFFSET;
        cfg_data = '0;
        for (int i = 0; i < TAG_POOL; i++) begin
            if (i < 4) tag_pool[i] = TAG_W'(i);
            else tag_pool[i] = TAG_W'({$urandom, $urandom});
        end
        tag_pool[TAG_POOL - 1] = '1;
        set_pool[0] = '0;
        set_pool[1] = '1;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The directory clear after reset runs while these writes go in.
        write_cfg(4'd6, 8'd8, 8'd254);
        line_a = line_addr(0, 0);
        line_b = line_addr(1, 0);

        send_msg(mk(FROM_ABOVE, MSG_REQUEST, line_a, 8'd0, 16'd0, 1'b0, 4'd15, 4'd15));
        send_msg(mk(FROM_ABOVE, MSG_DATA_REQ, line_a, 8'd0, 16'd0, 1'b1, 4'd1, 4'd1));
        send_msg(mk(FROM_ABOVE, MSG_UPDATE, line_a, 8'd255, 16'd0, 1'b1, 4'd1, 4'd0));
        send_msg(mk(FROM_BELOW, MSG_REQUEST, '1, 8'd255, 16'hFFFF, 1'b1, 4'd0, 4'd15));
        send_msg(mk(FROM_BELOW, MSG_EVICT, line_a, 8'd3, 16'd1, 1'b0, 4'd1, 4'd0));
        // A new line with no tokens stays valid, then counts saturate.
        send_msg(mk(FROM_ABOVE, MSG_DATA_TOK, line_a, 8'd8, 16'd0, 1'b0, 4'd0, 4'd1));
        send_msg(mk(FROM_ABOVE, MSG_DATA_TOK, line_a, 8'd8, 16'hFFFF, 1'b0, 4'd15, 4'd15));
        send_msg(mk(FROM_ABOVE, MSG_DATA_TOK, line_a, 8'd254, 16'd10, 1'b1, 4'd15, 4'd15));
        send_msg(mk(FROM_ABOVE, MSG_REQUEST, line_a, 8'd0, 16'd0, 1'b1, 4'd0, 4'd1));
        send_msg(mk(FROM_ABOVE, MSG_DATA_REQ, line_a, 8'd0, 16'd0, 1'b0, 4'd15, 4'd0));
        send_msg(mk(FROM_ABOVE, MSG_UPDATE, line_a, 8'd7, 16'd0, 1'b0, 4'd2, 4'd15));
        send_msg(mk(FROM_BELOW, MSG_EVICT, line_a, 8'd9, 16'hFFFF, 1'b1, 4'd15, 4'd0));
        send_msg(mk(FROM_ABOVE, MSG_DATA_TOK, line_b, 8'd100, 16'd2, 1'b0, 4'd15, 4'd15));
        send_msg(mk(FROM_BELOW, MSG_EVICT, line_b, 8'd200, 16'd3, 1'b0, 4'd1, 4'd0));
        send_msg(mk(FROM_BELOW, MSG_DATA_TOK, line_b, 8'd1, 16'd2, 1'b0, 4'd15, 4'd15));
        send_msg(mk(FROM_BELOW, MSG_EVICT, line_b, 8'd0, 16'd0, 1'b0, 4'd15, 4'd15));
        send_msg(mk(FROM_BELOW, MSG_DATA_TOK, line_a, 8'd4, 16'hFFFF, 1'b0, 4'd15, 4'd15));
        send_msg(mk(FROM_ABOVE, MSG_REQUEST, line_a, 8'd0, 16'd0, 1'b1, 4'd2, 4'd0));
        send_msg(mk(FROM_BELOW, KIND_SPARE_LO, line_a, 8'd0, 16'd0, 1'b0, 4'd1, 4'd0));
        send_msg(mk(FROM_ABOVE, KIND_SPARE_LO + 3'd1, line_a, 8'd0, 16'd0, 1'b0, 4'd1, 4'd1));
        send_msg(mk(FROM_ABOVE, KIND_SPARE_HI, line_a, 8'd0, 16'd0, 1'b0, 4'd15, 4'd0));
        send_msg(mk(FROM_ABOVE, MSG_EVICT, line_a, 8'd0, 16'd5, 1'b0, 4'd3, 4'd0));
        send_msg(mk(FROM_BELOW, MSG_UPDATE, line_a, 8'd0, 16'd0, 1'b0, 4'd1, 4'd0));
        // Data tokens from a sender outside the lower ring never allocate.
        send_msg(mk(FROM_ABOVE, MSG_DATA_TOK, line_b, 8'd255, 16'd4, 1'b0, 4'd15, 4'd15));

        run_random(PHASE_ITEMS);

        shifts = '{4'd0, 4'd12, 4'd15, 4'($urandom_range(0, 15))};
        los = '{8'd0, 8'd200, 8'd255, 8'($urandom)};
        his = '{8'd255, 8'd100, 8'd255, 8'($urandom)};
        for (int p = 0; p < 4; p++) begin
            s_tvalid = 1'b0;
            drain();
            write_cfg(shifts[p], los[p], his[p]);
            run_random(PHASE_ITEMS);
        end

        s_tvalid = 1'b0;
        drain();
        repeat (40) @(negedge aclk);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
